[hw/rtl/neighbor_mine_count_3x3_macros.svh]
// ----------------------------------------------------------------------------
// neighbor_mine_count_3x3_macros
// assertion helpers used by the neighbor mine counter top file
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_MINE_COUNT_3X3_MACROS_SVH
`define NEIGHBOR_MINE_COUNT_3X3_MACROS_SVH

// clocked assertion, quiet while reset is applied
`define NMC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds through reset
`define NMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/nmc_pkg.sv]
// ----------------------------------------------------------------------------
// nmc_pkg
// shared types and constants of the neighbor mine counter
// ----------------------------------------------------------------------------
package nmc_pkg;

  // default grid limits
  localparam int unsigned DEF_MAX_WIDTH  = 128;
  localparam int unsigned DEF_MAX_HEIGHT = 128;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cfg_reg_e;

  localparam logic [CFG_DATA_W-1:0] RESET_GRID_WIDTH  = 8'd8;
  localparam logic [CFG_DATA_W-1:0] RESET_GRID_HEIGHT = 8'd8;

  // row positions inside one window column
  localparam int unsigned ROW_BELOW = 0;
  localparam int unsigned ROW_CUR   = 1;
  localparam int unsigned ROW_ABOVE = 2;
  localparam int unsigned WIN_ROWS  = 3;

  // line buffer entry: bit one row up, bit two rows up
  localparam int unsigned LB_UP1 = 0;
  localparam int unsigned LB_UP2 = 1;
  localparam int unsigned LB_W   = 2;

  // result queue
  localparam int unsigned FIFO_DEPTH = 3;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int unsigned COUNT_W = 4;

  typedef struct packed {
    logic               mine_flag;
    logic [COUNT_W-1:0] mine_count;
    logic               last_cell;
  } result_t;

endpackage

[hw/rtl/nmc_line_buf.sv]
// ----------------------------------------------------------------------------
// nmc_line_buf
// two-row line buffer memory, one entry per column, with valid bits and
// write-to-read forwarding for back-to-back access of the same column
// ----------------------------------------------------------------------------
module nmc_line_buf #(
  parameter int unsigned MAX_WIDTH = nmc_pkg::DEF_MAX_WIDTH,
  localparam int unsigned COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clear_i,
  input  logic                     rd_en_i,
  input  logic [COL_W-1:0]         rd_addr_i,
  input  logic                     wr_en_i,
  input  logic [COL_W-1:0]         wr_addr_i,
  input  logic [nmc_pkg::LB_W-1:0] wr_data_i,
  output logic [nmc_pkg::LB_W-1:0] rd_data_o
);
  import nmc_pkg::*;

  logic [LB_W-1:0]      mem_q [MAX_WIDTH];
  logic [LB_W-1:0]      rd_q;
  logic [MAX_WIDTH-1:0] vld_q;
  logic                 rd_vld_q;
  logic                 fwd_q;
  logic [LB_W-1:0]      fwd_data_q;

  // memory write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // memory read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // per-entry valid bits, cleared on restart
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clear_i) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // read qualifiers and forwarding of a same-cycle write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else if (clear_i) begin
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else if (rd_en_i) begin
      rd_vld_q <= vld_q[rd_addr_i];
      fwd_q    <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= wr_data_i;
    end
  end

  // unwritten entries read as empty
  assign rd_data_o = fwd_q ? fwd_data_q : (rd_vld_q ? rd_q : '0);

endmodule

[hw/rtl/nmc_window.sv]
// ----------------------------------------------------------------------------
// nmc_window
// second stage: builds the 3x3 window from line buffer data, writes the
// shifted column back, tracks the reported position and forms the count
// ----------------------------------------------------------------------------
module nmc_window #(
  parameter int unsigned MAX_WIDTH  = nmc_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = nmc_pkg::DEF_MAX_HEIGHT,
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH),
  localparam int unsigned LEAD_W = $clog2(MAX_WIDTH + 2),
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clear_i,
  input  logic [LEAD_W-1:0]        width_i,
  input  logic [ROW_W-1:0]         height_i,
  input  logic                     acc_i,
  input  logic                     bit_i,
  input  logic [COL_W-1:0]         col_i,
  input  logic [nmc_pkg::LB_W-1:0] rd_data_i,
  output logic                     wr_en_o,
  output logic [COL_W-1:0]         wr_addr_o,
  output logic [nmc_pkg::LB_W-1:0] wr_data_o,
  output logic                     s1_valid_o,
  output logic                     push_o,
  output nmc_pkg::result_t         result_o
);
  import nmc_pkg::*;

  logic                s1_valid_q;
  logic                s1_bit_q;
  logic [COL_W-1:0]    s1_col_q;
  logic [WIN_ROWS-1:0] win0_q, win1_q;
  logic [WIN_ROWS-1:0] new_col;
  logic [LEAD_W-1:0]   lead_q;
  logic [COL_W-1:0]    oc_q;
  logic [ROW_W-1:0]    orow_q;
  logic                lead_done;
  logic                emit;
  logic                at_left, at_right, at_up, at_down;
  logic                col_end;
  logic                center;
  logic [COUNT_W-1:0]  count;

  // stage register for the accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (clear_i) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= acc_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_bit_q <= bit_i;
      s1_col_q <= col_i;
    end
  end

  // new column of the window: newest bit below, older rows above
  assign new_col[ROW_BELOW] = s1_bit_q;
  assign new_col[ROW_CUR]   = rd_data_i[LB_UP1];
  assign new_col[ROW_ABOVE] = rd_data_i[LB_UP2];

  // write back the column shifted by one row
  assign wr_en_o              = s1_valid_q;
  assign wr_addr_o            = s1_col_q;
  assign wr_data_o[LB_UP1]    = s1_bit_q;
  assign wr_data_o[LB_UP2]    = rd_data_i[LB_UP1];

  // window shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win0_q <= '0;
      win1_q <= '0;
    end else if (clear_i) begin
      win0_q <= '0;
      win1_q <= '0;
    end else if (s1_valid_q) begin
      win0_q <= new_col;
      win1_q <= win0_q;
    end
  end

  // edge tests for the reported cell
  assign lead_done = !(lead_q < (width_i + LEAD_W'(1)));
  assign emit      = s1_valid_q && lead_done && (orow_q < height_i);
  assign at_left   = (oc_q != '0);
  assign col_end   = !((LEAD_W'(oc_q) + LEAD_W'(1)) < width_i);
  assign at_right  = !col_end;
  assign at_up     = (orow_q != '0);
  assign at_down   = ((ROW_W + 1)'(orow_q) + (ROW_W + 1)'(1)) < (ROW_W + 1)'(height_i);

  // the window after this shift: new_col, win0_q, win1_q, center in win0_q
  assign center = win0_q[ROW_CUR];

  // neighbor sum, masked at the grid border, zero for a mine cell
  always_comb begin
    count = '0;
    if (!center) begin
      count = COUNT_W'(at_right && new_col[ROW_CUR])
            + COUNT_W'(at_left && win1_q[ROW_CUR])
            + COUNT_W'(at_down && win0_q[ROW_BELOW])
            + COUNT_W'(at_down && at_right && new_col[ROW_BELOW])
            + COUNT_W'(at_down && at_left && win1_q[ROW_BELOW])
            + COUNT_W'(at_up && win0_q[ROW_ABOVE])
            + COUNT_W'(at_up && at_right && new_col[ROW_ABOVE])
            + COUNT_W'(at_up && at_left && win1_q[ROW_ABOVE]);
    end
  end

  // lead-in count and reported position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= '0;
      oc_q   <= '0;
      orow_q <= '0;
    end else if (clear_i) begin
      lead_q <= '0;
      oc_q   <= '0;
      orow_q <= '0;
    end else if (s1_valid_q) begin
      if (!lead_done) begin
        lead_q <= lead_q + LEAD_W'(1);
      end else if (emit) begin
        if (col_end) begin
          oc_q   <= '0;
          orow_q <= orow_q + ROW_W'(1);
        end else begin
          oc_q <= oc_q + COL_W'(1);
        end
      end
    end
  end

  assign s1_valid_o          = s1_valid_q;
  assign push_o              = emit;
  assign result_o.mine_flag  = center;
  assign result_o.mine_count = count;
  assign result_o.last_cell  = col_end
                               && (((ROW_W + 1)'(orow_q) + (ROW_W + 1)'(1))
                                   == (ROW_W + 1)'(height_i));

endmodule

[hw/rtl/nmc_out_fifo.sv]
// ----------------------------------------------------------------------------
// nmc_out_fifo
// small result queue that parts the pipeline from the output stall
// ----------------------------------------------------------------------------
module nmc_out_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  nmc_pkg::result_t               data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output nmc_pkg::result_t               data_o,
  output logic [nmc_pkg::FIFO_CNT_W-1:0] count_o
);
  import nmc_pkg::*;

  result_t               buf_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  pop;

  assign pop = (cnt_q != '0) && !out_stall_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                            : wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                            : rd_ptr_q + FIFO_PTR_W'(1);
      end
      unique case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + FIFO_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - FIFO_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign data_o      = buf_q[rd_ptr_q];
  assign count_o     = cnt_q;

endmodule

[hw/rtl/neighbor_mine_count_3x3.sv]
// ----------------------------------------------------------------------------
// neighbor_mine_count_3x3
// minesweeper neighbor count over a raster cell stream, line buffer based
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in      | in  | in_valid_i/in_stall_o | in_kind_i, in_is_mine_i
//  out     | out | out_valid_o/out_stall_i | out_mine_flag_o, out_mine_count_o,
//          |     |                      | out_last_cell_o
//  cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  one beat a cycle while in_stall_o is low; a result passes the stage
//  register and the result queue after the beat that completes its window,
//  width+1 beats after its own cell. the registered read of the line buffer
//  memory sets the two-stage pipeline; a three-entry result queue keeps full
//  rate while the output stalls only briefly. reset and any register write
//  clear the window, counters and line buffer valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "neighbor_mine_count_3x3_macros.svh"

module neighbor_mine_count_3x3 #(
  parameter int unsigned MAX_WIDTH  = nmc_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = nmc_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           in_kind_i,
  input  logic                           in_is_mine_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           out_mine_flag_o,
  output logic [nmc_pkg::COUNT_W-1:0]    out_mine_count_o,
  output logic                           out_last_cell_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [nmc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [nmc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import nmc_pkg::*;

  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned LEAD_W  = $clog2(MAX_WIDTH + 2);
  localparam int unsigned ROW_W   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned WCMP_W  = (LEAD_W > CFG_DATA_W) ? LEAD_W : CFG_DATA_W;
  localparam int unsigned HCMP_W  = (ROW_W > CFG_DATA_W) ? ROW_W : CFG_DATA_W;
  localparam int unsigned OCC_W   = FIFO_CNT_W + 1;
  localparam logic        KIND_CELL = 1'b0;

  logic [CFG_DATA_W-1:0] grid_width_q, grid_height_q;
  logic                  cfg_we;
  logic [WCMP_W-1:0]     gw_ext, gw_eff;
  logic [HCMP_W-1:0]     gh_ext, gh_eff;
  logic [LEAD_W-1:0]     eff_width;
  logic [ROW_W-1:0]      eff_height;
  logic [COL_W-1:0]      ic_q;
  logic                  in_acc;
  logic                  cell_bit;
  logic                  wr_en;
  logic [COL_W-1:0]      wr_addr;
  logic [LB_W-1:0]       wr_data;
  logic [LB_W-1:0]       rd_data;
  logic                  s1_valid;
  logic                  push;
  result_t               result, head;
  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic [OCC_W-1:0]      occupancy;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= RESET_GRID_WIDTH;
      grid_height_q <= RESET_GRID_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_GRID_WIDTH:  grid_width_q  <= cfg_data_i;
        REG_GRID_HEIGHT: grid_height_q <= cfg_data_i;
      endcase
    end
  end

  // clamp geometry to the supported range
  assign gw_ext = WCMP_W'(grid_width_q);
  assign gw_eff = (gw_ext == '0) ? WCMP_W'(1)
                : (gw_ext > WCMP_W'(MAX_WIDTH)) ? WCMP_W'(MAX_WIDTH) : gw_ext;
  assign gh_ext = HCMP_W'(grid_height_q);
  assign gh_eff = (gh_ext == '0) ? HCMP_W'(1)
                : (gh_ext > HCMP_W'(MAX_HEIGHT)) ? HCMP_W'(MAX_HEIGHT) : gh_ext;
  assign eff_width  = LEAD_W'(gw_eff);
  assign eff_height = ROW_W'(gh_eff);

  // input beat, held off when the result queue could overfill
  assign occupancy  = OCC_W'(fifo_cnt) + OCC_W'(s1_valid);
  assign in_stall_o = occupancy > OCC_W'(FIFO_DEPTH - 1);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cell_bit   = (in_kind_i == KIND_CELL) && in_is_mine_i;

  // input column, selects the line buffer entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q <= '0;
    end else if (cfg_we) begin
      ic_q <= '0;
    end else if (in_acc) begin
      if ((LEAD_W'(ic_q) + LEAD_W'(1)) == eff_width) begin
        ic_q <= '0;
      end else begin
        ic_q <= ic_q + COL_W'(1);
      end
    end
  end

  nmc_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (cfg_we),
    .rd_en_i   (in_acc),
    .rd_addr_i (ic_q),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  nmc_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (cfg_we),
    .width_i    (eff_width),
    .height_i   (eff_height),
    .acc_i      (in_acc),
    .bit_i      (cell_bit),
    .col_i      (ic_q),
    .rd_data_i  (rd_data),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .s1_valid_o (s1_valid),
    .push_o     (push),
    .result_o   (result)
  );

  nmc_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (result),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (head),
    .count_o     (fifo_cnt)
  );

  assign out_mine_flag_o  = head.mine_flag;
  assign out_mine_count_o = head.mine_count;
  assign out_last_cell_o  = head.last_cell;

  // checks
  `NMC_ASSERT(a_acc_enters_stage, clk_i, rst_ni, in_acc |=> s1_valid, "accepted beat lost")
  `NMC_ASSERT(a_queue_bound, clk_i, rst_ni, occupancy <= OCC_W'(FIFO_DEPTH), "queue overfill")
  `NMC_ASSERT(a_mine_zero, clk_i, rst_ni, (out_valid_o && out_mine_flag_o) |-> (out_mine_count_o == '0), "mine with count")
  `NMC_ASSERT(a_count_range, clk_i, rst_ni, out_valid_o |-> (out_mine_count_o <= COUNT_W'(8)), "count above eight")

endmodule

[tb/nmc_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmc_result_checker
// watches the cell, result and register channels of the neighbor mine
// counter, keeps its own model of the sliding three-row window and compares
// every result beat, in order, with the predicted flag, neighbor count and last mark
// ----------------------------------------------------------------------------
module nmc_result_checker #(
  parameter int unsigned MAX_WIDTH  = nmc_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = nmc_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic                           in_kind_i,
  input  logic                           in_is_mine_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic                           out_mine_flag_i,
  input  logic [nmc_pkg::COUNT_W-1:0]    out_mine_count_i,
  input  logic                           out_last_cell_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [nmc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [nmc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           end_check_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o,
  output int unsigned                    checked_o
);
  import nmc_pkg::*;

  // two full rows plus three cells of history, newest cell at bit 0
  localparam int unsigned HIST_LEN  = 2 * MAX_WIDTH + 3;

  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  logic [HIST_LEN-1:0]   cell_hist;
  int unsigned           lead_beats;
  int unsigned           rep_col;
  int unsigned           rep_row;
  result_t               count_q[$];
  int unsigned           errors  = 0;
  int unsigned           checked = 0;
  logic                  end_done = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("%0t ns nmc check: %s", $realtime, msg);
    errors++;
  endtask

  // register value as the block uses it
  function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                            input int unsigned lim);
    if (v == '0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  // mine bit at offset d (raster order) from the reported cell
  function automatic int unsigned hist_bit(input int w, input int d);
    int idx;
    idx = w + 1 - d;
    if (idx < 0 || idx >= int'(HIST_LEN)) return 0;
    return 32'(cell_hist[idx]);
  endfunction

  task automatic restart_stream();
    cell_hist  = '0;
    lead_beats = 0;
    rep_col    = 0;
    rep_row    = 0;
  endtask

  // shift one cell in and work out the result it completes, if any
  task automatic predict_beat(input logic kind, input logic mine);
    int unsigned w, h, c, r, cnt;
    int          sw;
    logic        flag, lft, rgt, up, dn;
    result_t     res;
    w  = clamp_dim(width_reg, MAX_WIDTH);
    h  = clamp_dim(height_reg, MAX_HEIGHT);
    sw = int'(w);
    cell_hist = {cell_hist[HIST_LEN-2:0], (!kind && mine)};
    if (lead_beats < w + 1) begin
      lead_beats++;
      return;
    end
    if (rep_row >= h) return;
    c    = rep_col;
    r    = rep_row;
    cnt  = 0;
    flag = (hist_bit(sw, 0) != 0);
    if (!flag) begin
      lft = (c > 0);
      rgt = (c + 1 < w);
      up  = (r > 0);
      dn  = (r + 1 < h);
      if (up) begin
        cnt += hist_bit(sw, -sw);
        if (lft) cnt += hist_bit(sw, -sw - 1);
        if (rgt) cnt += hist_bit(sw, -sw + 1);
      end
      if (lft) cnt += hist_bit(sw, -1);
      if (rgt) cnt += hist_bit(sw, 1);
      if (dn) begin
        cnt += hist_bit(sw, sw);
        if (lft) cnt += hist_bit(sw, sw - 1);
        if (rgt) cnt += hist_bit(sw, sw + 1);
      end
    end
    res.mine_flag  = flag;
    res.mine_count = cnt[COUNT_W-1:0];
    res.last_cell  = (r + 1 == h) && (c + 1 == w);
    count_q.push_back(res);
    if (c + 1 >= w) begin
      rep_col = 0;
      rep_row = r + 1;
    end else begin
      rep_col = c + 1;
    end
  endtask

  // channel monitor: results first, then register writes, then cells
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      width_reg  = RESET_GRID_WIDTH;
      height_reg = RESET_GRID_HEIGHT;
      restart_stream();
      count_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (count_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat: flag %0b count %0d last %0b",
                                    out_mine_flag_i, out_mine_count_i, out_last_cell_i));
        end else begin
          want = count_q.pop_front();
          checked++;
          if (out_mine_flag_i !== want.mine_flag) begin
            report_mismatch($sformatf("result %0d: mine_flag %0b, want %0b",
                                      checked, out_mine_flag_i, want.mine_flag));
          end
          if (out_mine_count_i !== want.mine_count) begin
            report_mismatch($sformatf("result %0d: mine_count %0d, want %0d",
                                      checked, out_mine_count_i, want.mine_count));
          end
          if (out_last_cell_i !== want.last_cell) begin
            report_mismatch($sformatf("result %0d: last_cell %0b, want %0b",
                                      checked, out_last_cell_i, want.last_cell));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_GRID_WIDTH:  width_reg  = cfg_data_i;
          REG_GRID_HEIGHT: height_reg = cfg_data_i;
          default: ;
        endcase
        restart_stream();
      end
      if (in_valid_i && !in_stall_i) begin
        predict_beat(in_kind_i, in_is_mine_i);
      end
      // anything still queued at the end never showed up
      if (end_check_i && !end_done) begin
        end_done = 1'b1;
        if (count_q.size() != 0) begin
          report_mismatch($sformatf("%0d expected results never arrived", count_q.size()));
        end
      end
    end
    fail_count_o <= errors;
    pending_o    <= count_q.size();
    checked_o    <= checked;
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the neighbor mine counter: directed small grids,
// then random grids of random size and mine density with drain beats, stray
// beats and cut-off streams, under three sender and receiver idle patterns
// ----------------------------------------------------------------------------
module tb_top;
  import nmc_pkg::*;

  localparam real         CLK_PERIOD    = 12.0;
  localparam int unsigned MAX_WIDTH     = DEF_MAX_WIDTH;
  localparam int unsigned MAX_HEIGHT    = DEF_MAX_HEIGHT;
  localparam int unsigned LIMIT_CYCLES  = 300_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT   = 20_000;
  localparam int unsigned PHASE_BEATS   = 40;

  localparam int unsigned SEND_PCT[3] = '{38, 61, 0};
  localparam int unsigned RECV_PCT[3] = '{61, 38, 0};

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic                  in_kind_i    = 1'b0;
  logic                  in_is_mine_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic                  out_mine_flag_o;
  logic [COUNT_W-1:0]    out_mine_count_o;
  logic                  out_last_cell_o;
  logic                  cfg_valid_i  = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  end_check    = 1'b0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned send_idle   = 38;
  int unsigned recv_idle   = 61;
  int unsigned beat_count  = 0;
  int unsigned grid_count  = 0;

  logic [CFG_DATA_W-1:0] width_val  = RESET_GRID_WIDTH;
  logic [CFG_DATA_W-1:0] height_val = RESET_GRID_HEIGHT;

  always #(CLK_PERIOD / 2.0) clk_i = ~clk_i;

  neighbor_mine_count_3x3 #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_kind_i        (in_kind_i),
    .in_is_mine_i     (in_is_mine_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_mine_flag_o  (out_mine_flag_o),
    .out_mine_count_o (out_mine_count_o),
    .out_last_cell_o  (out_last_cell_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  nmc_result_checker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_kind_i        (in_kind_i),
    .in_is_mine_i     (in_is_mine_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_mine_flag_i  (out_mine_flag_o),
    .out_mine_count_i (out_mine_count_o),
    .out_last_cell_i  (out_last_cell_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .end_check_i      (end_check),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle);
  end

  // hard stop
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("[neighbor_mine_count_3x3] ERROR");
    $finish;
  end

  function automatic int unsigned eff_dim(input logic [CFG_DATA_W-1:0] v,
                                          input int unsigned lim);
    if (v == '0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  // one cell beat, with a random gap in front of it
  task automatic send_beat(input logic kind, input logic mine);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_kind_i    <= kind;
    in_is_mine_i <= mine;
    do @(posedge clk_i); while (in_stall_o);
    beat_count++;
  endtask

  // wait for the last result, then let the pipeline run empty
  task automatic wait_idle();
    int unsigned waited;
    waited = 0;
    @(posedge clk_i);
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register writes between grids; at least one, which restarts the stream
  task automatic set_grid(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    logic wr_w, wr_h;
    wr_w = (w != width_val) || ($urandom_range(0, 1) == 1);
    wr_h = (h != height_val) || !wr_w || ($urandom_range(0, 1) == 1);
    cfg_valid_i <= 1'b1;
    if (wr_w) begin
      cfg_index_i <= REG_GRID_WIDTH;
      cfg_data_i  <= w;
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    if (wr_h) begin
      cfg_index_i <= REG_GRID_HEIGHT;
      cfg_data_i  <= h;
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    width_val  = w;
    height_val = h;
    grid_count++;
  endtask

  // one grid with drain beats; now and then cut short or followed by strays
  task automatic stream_grid(input int unsigned ew, input int unsigned eh,
                             input bit may_break);
    int unsigned cells, total, stop_at, density;
    logic        kind, mine;
    cells = ew * eh;
    total = cells + ew + 1;
    case ($urandom_range(0, 5))
      0:       density = 0;
      1:       density = 100;
      default: density = $urandom_range(10, 60);
    endcase
    stop_at = (may_break && $urandom_range(0, 9) == 0) ? $urandom_range(1, total - 1) : total;
    for (int unsigned i = 0; i < stop_at; i++) begin
      if (i < cells) begin
        // a drain beat inside the grid counts as an empty cell
        kind = ($urandom_range(0, 19) == 0);
        mine = ($urandom_range(0, 99) < density);
      end else begin
        // drain beats, sometimes a grid cell past the grid as filler
        kind = ($urandom_range(0, 3) != 0);
        mine = 1'($urandom_range(0, 1));
      end
      send_beat(kind, mine);
    end
    // beats past the last result are ignored
    if (stop_at == total && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    in_valid_i <= 1'b0;
    wait_idle();
  endtask

  initial begin : stimulus
    int unsigned           phase_start;
    logic [CFG_DATA_W-1:0] w_sel, h_sel;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero registers act as a 1x1 grid; one stray beat after the result
    set_grid('0, '0);
    send_beat(1'b0, 1'b1);
    send_beat(1'b1, 1'b0);
    send_beat(1'b1, 1'b1);
    send_beat(1'b0, 1'b1);
    in_valid_i <= 1'b0;
    wait_idle();

    // 3x3 ring of mines around a drain beat with the mine bit set
    set_grid(8'd3, 8'd3);
    for (int i = 0; i < 9; i++) begin
      send_beat(i == 4, 1'b1);
    end
    send_beat(1'b0, 1'b1);
    repeat (3) send_beat(1'b1, 1'b0);
    in_valid_i <= 1'b0;
    wait_idle();

    // single column: empty cell over a mine
    set_grid(8'd1, 8'd2);
    send_beat(1'b0, 1'b0);
    send_beat(1'b0, 1'b1);
    repeat (2) send_beat(1'b1, 1'b0);
    in_valid_i <= 1'b0;
    wait_idle();

    // random grids under each idle pattern
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = SEND_PCT[ph];
      recv_idle <= RECV_PCT[ph];
      phase_start = beat_count;
      while (beat_count - phase_start < PHASE_BEATS) begin
        w_sel = CFG_DATA_W'($urandom_range(1, 10));
        h_sel = CFG_DATA_W'($urandom_range(1, 6));
        if ($urandom_range(0, 14) == 0) begin
          w_sel = CFG_DATA_W'($urandom_range(11, 40));
          h_sel = CFG_DATA_W'($urandom_range(1, 3));
        end
        if ($urandom_range(0, 9) == 0) w_sel = '0;
        if ($urandom_range(0, 9) == 0) h_sel = '0;
        set_grid(w_sel, h_sel);
        stream_grid(eff_dim(w_sel, MAX_WIDTH), eff_dim(h_sel, MAX_HEIGHT), 1'b1);
      end
      // oversized width value clamps to the full line buffer width
      if (ph == 0) begin
        set_grid(8'hFF, 8'd1);
        stream_grid(MAX_WIDTH, 1, 1'b0);
      end
    end

    end_check <= 1'b1;
    repeat (3) @(posedge clk_i);
    $display("run covered %0d cell beats and %0d compared results over %0d grid settings,",
             beat_count, checked, grid_count);
    $display("from 1x1 up to full width, under three idle patterns");
    if (fail_count == 0) begin
      $display("[neighbor_mine_count_3x3] OK");
    end else begin
      $display("[neighbor_mine_count_3x3] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/nmc_pkg.sv
hw/rtl/nmc_line_buf.sv
hw/rtl/nmc_window.sv
hw/rtl/nmc_out_fifo.sv
hw/rtl/neighbor_mine_count_3x3.sv
tb/nmc_result_checker.sv
tb/tb_top.sv
